### src/bst_pkg.sv
// Shared constants, command codes and the push record for the breadth-first
// spanning tree engine. Used by the engine, the output stage and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bst_pkg;

    localparam int NODE_W    = 6;
    localparam int SLOT_W    = 4;
    localparam int DEG_W     = 5;
    localparam int PTR_W     = 7;
    localparam int MAX_NODES = 64;
    localparam int NB_DEPTH  = 1024;

    localparam logic [DEG_W-1:0] MAX_DEGREE = 5'd16;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    typedef logic [NODE_W-1:0] node_t;

    // One result item handed from the engine to the output stage.
    typedef struct packed {
        logic  valid;
        node_t parent;
        node_t child;
        logic  edge_valid;
        logic  last;
    } push_t;

endpackage
`default_nettype wire

### src/bst_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Standalone; used for every memory of the engine.
`timescale 1ns / 1ps
`default_nettype none
module bst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### src/bst_out_stage.sv
// Output register of the engine: holds one result item until it is taken.
// Depends on bst_pkg for the push record.
`timescale 1ns / 1ps
`default_nettype none
module bst_out_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire bst_pkg::push_t push,
    output logic                out_free,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [15:0]         m_tdata,
    output logic                m_tlast,
    output logic [0:0]          m_tuser
);

    logic           valid_reg;
    logic           valid_next;
    bst_pkg::push_t data_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (push.valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            data_reg <= push;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, data_reg.child, data_reg.parent};
    assign m_tlast  = data_reg.last;
    assign m_tuser  = data_reg.edge_valid;

endmodule
`default_nettype wire

### src/bst_engine.sv
// Command sequencer of the engine: graph updates and the breadth-first walk.
// Depends on bst_pkg and bst_ram (adjacency, degree and queue memories).
`timescale 1ns / 1ps
`default_nettype none
module bst_engine (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              in_cmd,
    input  wire bst_pkg::node_t          in_src,
    input  wire bst_pkg::node_t          in_dst,
    input  wire logic                    out_free,
    output bst_pkg::push_t               push
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ADD    = 3'd1;
    localparam logic [2:0] ST_POP    = 3'd2;
    localparam logic [2:0] ST_DEG    = 3'd3;
    localparam logic [2:0] ST_DEGW   = 3'd4;
    localparam logic [2:0] ST_SCAN   = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    localparam int NB_AW = $clog2(bst_pkg::NB_DEPTH);
    localparam int Q_AW  = $clog2(bst_pkg::MAX_NODES);

    logic [2:0] state_reg, state_next;
    bst_pkg::node_t src_reg, src_next;
    bst_pkg::node_t dst_reg, dst_next;
    bst_pkg::node_t node_reg, node_next;
    logic [bst_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [bst_pkg::DEG_W-1:0] deg_reg, deg_next;
    logic [bst_pkg::PTR_W-1:0] head_reg, head_next;
    logic [bst_pkg::PTR_W-1:0] tail_reg, tail_next;
    logic [bst_pkg::MAX_NODES-1:0] visited_reg, visited_next;
    logic [bst_pkg::MAX_NODES-1:0] degv_reg, degv_next;
    bst_pkg::node_t deg_addr_reg;
    logic pend_valid_reg, pend_valid_next;
    bst_pkg::node_t pend_parent_reg, pend_parent_next;
    bst_pkg::node_t pend_child_reg, pend_child_next;

    // Memory ports.
    logic                       nb_we;
    logic [NB_AW-1:0]           nb_waddr, nb_raddr;
    bst_pkg::node_t             nb_rdata;
    logic                       dg_we;
    bst_pkg::node_t             dg_raddr;
    logic [bst_pkg::DEG_W-1:0]  dg_wdata, dg_rdata;
    logic                       q_we;
    logic [Q_AW-1:0]            q_waddr;
    bst_pkg::node_t             q_wdata, q_rdata;

    logic                       accept;
    logic [bst_pkg::DEG_W-1:0]  deg_cur;
    logic                       disc;
    logic                       stall;
    logic [bst_pkg::SLOT_W-1:0] slot_rd;
    logic                       slot_last;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // An entry never written since the last clear reads as zero degree.
    assign deg_cur   = degv_reg[deg_addr_reg] ? dg_rdata : '0;
    assign disc      = !visited_reg[nb_rdata];
    assign stall     = disc && pend_valid_reg && !out_free;
    assign slot_rd   = stall ? slot_reg : slot_reg + 1'b1;
    assign slot_last = ({1'b0, slot_reg} == (deg_reg - 1'b1));

    assign dg_raddr = (state_reg == ST_DEG) ? q_rdata : in_src;
    assign nb_raddr = (state_reg == ST_SCAN) ? {node_reg, slot_rd}
                                             : {node_reg, {bst_pkg::SLOT_W{1'b0}}};
    assign nb_waddr = {src_reg, deg_cur[bst_pkg::SLOT_W-1:0]};
    assign dg_wdata = deg_cur + 1'b1;

    always_comb begin
        state_next       = state_reg;
        src_next         = src_reg;
        dst_next         = dst_reg;
        node_next        = node_reg;
        slot_next        = slot_reg;
        deg_next         = deg_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        visited_next     = visited_reg;
        degv_next        = degv_reg;
        pend_valid_next  = pend_valid_reg;
        pend_parent_next = pend_parent_reg;
        pend_child_next  = pend_child_reg;
        nb_we            = 1'b0;
        dg_we            = 1'b0;
        q_we             = 1'b0;
        q_waddr          = tail_reg[Q_AW-1:0];
        q_wdata          = nb_rdata;
        push             = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    src_next = in_src;
                    dst_next = in_dst;
                    priority if (in_cmd == bst_pkg::CMD_CLEAR) begin
                        degv_next = '0;
                    end else if (in_cmd == bst_pkg::CMD_ADD) begin
                        state_next = ST_ADD;
                    end else if (in_cmd == bst_pkg::CMD_RUN) begin
                        head_next       = '0;
                        pend_valid_next = 1'b0;
                        visited_next    = '0;
                        if (in_src != '0) begin
                            visited_next = bst_pkg::MAX_NODES'(1) << in_src;
                            q_we         = 1'b1;
                            q_waddr      = '0;
                            q_wdata      = in_src;
                            tail_next    = bst_pkg::PTR_W'(1);
                            state_next   = ST_POP;
                        end else begin
                            tail_next  = '0;
                            state_next = ST_FINISH;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ADD: begin
                if (src_reg != '0 && dst_reg != '0 && deg_cur < bst_pkg::MAX_DEGREE) begin
                    nb_we     = 1'b1;
                    dg_we     = 1'b1;
                    degv_next = degv_reg | (bst_pkg::MAX_NODES'(1) << src_reg);
                end
                state_next = ST_IDLE;
            end
            ST_POP: begin
                state_next = (head_reg == tail_reg) ? ST_FINISH : ST_DEG;
            end
            ST_DEG: begin
                node_next  = q_rdata;
                state_next = ST_DEGW;
            end
            ST_DEGW: begin
                deg_next  = deg_cur;
                slot_next = '0;
                if (deg_cur == '0) begin
                    head_next  = head_reg + 1'b1;
                    state_next = ST_POP;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    // Every node is 1..63, so the queue and the edge count stay in range.
                    if (disc) begin
                        visited_next     = visited_reg | (bst_pkg::MAX_NODES'(1) << nb_rdata);
                        q_we             = 1'b1;
                        tail_next        = tail_reg + 1'b1;
                        pend_valid_next  = 1'b1;
                        pend_parent_next = node_reg;
                        pend_child_next  = nb_rdata;
                        push.valid       = pend_valid_reg;
                        push.parent      = pend_parent_reg;
                        push.child       = pend_child_reg;
                        push.edge_valid  = 1'b1;
                    end
                    slot_next = slot_reg + 1'b1;
                    if (slot_last) begin
                        head_next  = head_reg + 1'b1;
                        state_next = ST_POP;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    push.valid      = 1'b1;
                    push.parent     = pend_valid_reg ? pend_parent_reg : '0;
                    push.child      = pend_valid_reg ? pend_child_reg : '0;
                    push.edge_valid = pend_valid_reg;
                    push.last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            visited_reg    <= '0;
            degv_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            visited_reg    <= visited_next;
            degv_reg       <= degv_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg         <= src_next;
        dst_reg         <= dst_next;
        node_reg        <= node_next;
        slot_reg        <= slot_next;
        deg_reg         <= deg_next;
        deg_addr_reg    <= dg_raddr;
        pend_parent_reg <= pend_parent_next;
        pend_child_reg  <= pend_child_next;
    end

    bst_ram #(
        .WIDTH(bst_pkg::NODE_W),
        .DEPTH(bst_pkg::NB_DEPTH)
    ) u_nb_ram (
        .aclk (aclk),
        .we   (nb_we),
        .waddr(nb_waddr),
        .wdata(dst_reg),
        .raddr(nb_raddr),
        .rdata(nb_rdata)
    );

    bst_ram #(
        .WIDTH(bst_pkg::DEG_W),
        .DEPTH(bst_pkg::MAX_NODES)
    ) u_deg_ram (
        .aclk (aclk),
        .we   (dg_we),
        .waddr(src_reg),
        .wdata(dg_wdata),
        .raddr(dg_raddr),
        .rdata(dg_rdata)
    );

    bst_ram #(
        .WIDTH(bst_pkg::NODE_W),
        .DEPTH(bst_pkg::MAX_NODES)
    ) u_queue_ram (
        .aclk (aclk),
        .we   (q_we),
        .waddr(q_waddr),
        .wdata(q_wdata),
        .raddr(head_reg[Q_AW-1:0]),
        .rdata(q_rdata)
    );

endmodule
`default_nettype wire

### src/bfs_spanning_tree_top.sv
// Top level of the breadth-first spanning tree engine.
// Depends on bst_pkg, bst_engine (with its bst_ram memories) and bst_out_stage.
//
//   Channel  Direction  tdata (low bit first)         tuser        tlast
//   s_       in         src_node[5:0], dst_node[11:6]  cmd[1:0]     -
//   m_       out        parent_node[5:0], child[11:6]  edge_valid   last item of a run
//
// A clear item empties the graph; an edge item first reads the node's degree,
// then writes the adjacency slot and the new degree. A run takes each node
// from the queue, reads its degree and then scans each stored adjacency slot
// through the adjacency memory's single read port, one slot a cycle unless
// the scan is stalled, and then closes the run with a final item.
// Reset (aresetn low, synchronous) empties the graph and the output register.
// A stalled result channel holds the scan only when a new tree edge must be
// handed on while the output register is still full. The closing item of a
// run waits in the same way for a free output register.
`timescale 1ns / 1ps
`default_nettype none
module bfs_spanning_tree_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // src_node[5:0], dst_node[11:6], zero fill
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // parent_node[5:0], child_node[11:6], zero fill
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // edge_valid[0]
);

    bst_pkg::push_t push;
    logic           out_free;

    // The engine walks the graph; each tree edge is held back until the next one
    // is found, so that the final edge of a run can carry tlast.
    bst_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_cmd  (s_tuser),
        .in_src  (s_tdata[5:0]),
        .in_dst  (s_tdata[11:6]),
        .out_free(out_free),
        .push    (push)
    );

    // The output register decouples the walk from the result consumer.
    bst_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .out_free(out_free),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule
`default_nettype wire

### src/bst_checker.sv
// Port-level checker for the breadth-first spanning tree engine, bound to
// the top level. Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module bst_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [0:0]  m_tuser
);

    // A held result item stays valid and keeps its data and last flag.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // An empty result is always the closing item with zero nodes.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[11:0] == 12'd0))
        else $error("empty result malformed");

    // A tree edge joins two distinct real nodes.
    a_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[11:6] != 6'd0) && (m_tdata[5:0] != 6'd0)
                                   && (m_tdata[11:6] != m_tdata[5:0]))
        else $error("tree edge with bad nodes");

    // No item is taken while a run still has edges to deliver.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted during a run");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind bfs_spanning_tree_top bst_checker u_bst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
);
`default_nettype wire
